/* hw/rtl/eds_pkg.sv */
// Shared types and codes for the elevator disk request scheduler.
// Used by eds_cell and elevator_disk_request_scheduler; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eds_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int KEY_W = 42;
    localparam int PAY_W = 27;
    localparam int ORD_W = 8;
    localparam int CYL_W = 10;
    localparam int SEEK_W = 32;

    // command codes
    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_SERVED   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_DUP      = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // positions of the slot indexes carried beside the token
    localparam int IX_SUCC = 0;
    localparam int IX_PRED = 1;
    localparam int IX_BIG  = 2;
    localparam int IX_FIFO = 3;
    localparam int IX_FREE = 4;
    localparam int IX_N    = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // running search result handed from cell to cell
    typedef struct packed {
        logic             succ_f;
        logic [KEY_W-1:0] succ_key;
        logic             pred_f;
        logic [KEY_W-1:0] pred_key;
        logic             big_f;
        logic [KEY_W-1:0] big_key;
        logic             fifo_f;
        logic [ORD_W-1:0] fifo_age;
        logic             free_f;
        logic             dup;
        logic [CYL_W-1:0] sel_cyl;
        logic [PAY_W-1:0] sel_pay;
    } t_token;

    // values broadcast to every cell
    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] ref_key;
        logic [KEY_W-1:0] new_key;
        logic [ORD_W-1:0] ins_cnt;
        logic             wr_en;
        logic [PAY_W-1:0] wr_pay;
        logic             clr_en;
    } t_bcast;

endpackage

`default_nettype wire

/* hw/rtl/eds_cell.sv */
// One table slot of the scheduler plus its stage of the search token chain.
// Depends on eds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eds_cell #(
    parameter int TABLE_DEPTH = eds_pkg::TABLE_DEPTH_DEF,
    parameter int IDX         = 0,
    localparam int IW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  eds_pkg::t_bcast                       i_bc,
    input  wire  [IW-1:0]                         i_ref_idx,
    input  wire  [IW-1:0]                         i_wr_idx,
    input  wire  [IW-1:0]                         i_clr_idx,
    input  eds_pkg::t_token                       i_tok,
    input  wire  [eds_pkg::IX_N-1:0][IW-1:0]      i_tix,
    output eds_pkg::t_token                       o_tok,
    output logic [eds_pkg::IX_N-1:0][IW-1:0]      o_tix,
    output logic                                  o_valid
);

    localparam logic [IW-1:0] MY = IW'(IDX);

    logic                        r_valid;
    logic [eds_pkg::KEY_W-1:0]   r_key;
    logic [eds_pkg::PAY_W-1:0]   r_pay;
    logic [eds_pkg::ORD_W-1:0]   r_ord;
    eds_pkg::t_token             r_tok;
    logic [eds_pkg::IX_N-1:0][IW-1:0] r_tix;
    eds_pkg::t_token             n_tok;
    logic [eds_pkg::IX_N-1:0][IW-1:0] n_tix;

    logic                        eq_ref, lt_ref, gt_ref, not_ref;
    logic                        less_js, less_sj;
    logic [eds_pkg::ORD_W-1:0]   age;
    logic                        take_fifo;

    always_comb begin
        eq_ref  = (r_key == i_bc.ref_key);
        lt_ref  = (r_key < i_bc.ref_key);
        gt_ref  = !eq_ref && !lt_ref;
        not_ref = (MY != i_ref_idx);
        less_js = lt_ref || (eq_ref && (MY < i_ref_idx));
        less_sj = gt_ref || (eq_ref && (i_ref_idx < MY));
        age     = i_bc.ins_cnt - r_ord - eds_pkg::ORD_W'(1);
        take_fifo = r_valid && (!i_tok.fifo_f || (age > i_tok.fifo_age));

        n_tok = i_tok;
        n_tix = i_tix;
        if (r_valid && not_ref && less_sj &&
            (!i_tok.succ_f || (r_key < i_tok.succ_key))) begin
            n_tok.succ_f   = 1'b1;
            n_tok.succ_key = r_key;
            n_tix[eds_pkg::IX_SUCC] = MY;
        end
        if (r_valid && not_ref && less_js &&
            (!i_tok.pred_f || (r_key >= i_tok.pred_key))) begin
            n_tok.pred_f   = 1'b1;
            n_tok.pred_key = r_key;
            n_tix[eds_pkg::IX_PRED] = MY;
        end
        if (r_valid && (!i_tok.big_f || (r_key >= i_tok.big_key))) begin
            n_tok.big_f   = 1'b1;
            n_tok.big_key = r_key;
            n_tix[eds_pkg::IX_BIG] = MY;
        end
        if (take_fifo) begin
            n_tok.fifo_f   = 1'b1;
            n_tok.fifo_age = age;
            n_tix[eds_pkg::IX_FIFO] = MY;
        end
        if (!r_valid && !i_tok.free_f) begin
            n_tok.free_f = 1'b1;
            n_tix[eds_pkg::IX_FREE] = MY;
        end
        if (r_valid && (r_key == i_bc.new_key)) begin
            n_tok.dup = 1'b1;
        end
        // served entry: the cursor slot when sweeping, the oldest in arrival order
        if (i_bc.mode ? (r_valid && !not_ref) : take_fifo) begin
            n_tok.sel_cyl = r_key[eds_pkg::KEY_W-1 -: eds_pkg::CYL_W];
            n_tok.sel_pay = r_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_bc.wr_en && (i_wr_idx == MY)) begin
                r_valid <= 1'b1;
            end else if (i_bc.clr_en && (i_clr_idx == MY)) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bc.wr_en && (i_wr_idx == MY)) begin
            r_key <= i_bc.new_key;
            r_pay <= i_bc.wr_pay;
            r_ord <= i_bc.ins_cnt;
        end
        r_tok <= n_tok;
        r_tix <= n_tix;
    end

    assign o_tok   = r_tok;
    assign o_tix   = r_tix;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hw/rtl/elevator_disk_request_scheduler.sv */
// Top level of the elevator disk request scheduler: control, cursor, seek count.
// Depends on eds_pkg and eds_cell.
`timescale 1ns / 1ps
`default_nettype none

// A table of TABLE_DEPTH request slots, one per cell in a chain. Each command
// beat (put or serve) launches a search token that walks the chain one cell
// per cycle. A serve in sweep order that turns at the top first has to find
// the largest entry and so walks the chain a second time. A serve on an empty
// table answers without a search. One command is worked on at a time; a new
// one is taken while the previous result still waits on the output.
module elevator_disk_request_scheduler #(
    parameter int TABLE_DEPTH = eds_pkg::TABLE_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_cmd,
    input  wire  [9:0]  i_cylinder,
    input  wire  [3:0]  i_head,
    input  wire  [5:0]  i_sector,
    input  wire  [31:0] i_arrival_time,
    input  wire         i_is_read,
    input  wire  [15:0] i_data_tag,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_status,
    output logic [9:0]  o_out_cylinder,
    output logic [3:0]  o_out_head,
    output logic [5:0]  o_out_sector,
    output logic        o_out_is_read,
    output logic [15:0] o_out_data_tag,
    output logic [31:0] o_seek_count,
    output logic        o_table_empty
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    eds_pkg::t_state r_state, n_state;

    logic                        r_mode;
    logic                        r_cmd;
    logic [eds_pkg::KEY_W-1:0]   r_key;
    logic [eds_pkg::PAY_W-1:0]   r_pay;
    logic [eds_pkg::ORD_W-1:0]   r_ins;
    logic [IW-1:0]               r_cursor;
    logic [eds_pkg::KEY_W-1:0]   r_cur_key;
    logic                        r_at_end;
    logic                        r_up;
    logic [eds_pkg::CYL_W-1:0]   r_last_cyl;
    logic [eds_pkg::SEEK_W-1:0]  r_seek;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_cnt;
    logic                        r_phase;   // 1: cursor known, neighbor search

    logic [2:0]                  r_res_status;
    logic [eds_pkg::CYL_W-1:0]   r_res_cyl;
    logic [eds_pkg::PAY_W-1:0]   r_res_pay;

    logic                        r_out_valid;
    logic [2:0]                  r_o_status;
    logic [eds_pkg::CYL_W-1:0]   r_o_cyl;
    logic [eds_pkg::PAY_W-1:0]   r_o_pay;
    logic [eds_pkg::SEEK_W-1:0]  r_o_seek;
    logic                        r_o_empty;

    eds_pkg::t_token             tok [TABLE_DEPTH];
    logic [eds_pkg::IX_N-1:0][IW-1:0] tix [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]      v_vec;
    eds_pkg::t_bcast             bc;
    eds_pkg::t_token             t_end;
    logic [eds_pkg::IX_N-1:0][IW-1:0] x_end;

    logic in_acc, out_free, scan_end, put_ok, serve_fin, seek_hit;
    logic [IW-1:0] clr_idx;
    logic cur_live;

    assign t_end    = tok[TABLE_DEPTH-1];
    assign x_end    = tix[TABLE_DEPTH-1];
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign scan_end = (r_state == eds_pkg::S_SCAN) && (r_cnt == DEPTH_C);
    assign put_ok   = scan_end && (r_cmd == eds_pkg::CMD_PUT) &&
                      !(r_mode && t_end.dup) && t_end.free_f;
    assign serve_fin = scan_end && (r_cmd == eds_pkg::CMD_SERVE) &&
                       (!r_mode || r_phase);
    assign clr_idx  = r_mode ? r_cursor : x_end[eds_pkg::IX_FIFO];
    assign seek_hit = !r_mode || (t_end.sel_cyl != r_last_cyl);
    assign cur_live = !r_at_end && v_vec[r_cursor];

    always_comb begin
        bc.mode    = r_mode;
        bc.ref_key = r_cur_key;
        bc.new_key = r_key;
        bc.ins_cnt = r_ins;
        bc.wr_en   = put_ok;
        bc.wr_pay  = r_pay;
        bc.clr_en  = serve_fin;
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        eds_pkg::t_token                  tok_in;
        logic [eds_pkg::IX_N-1:0][IW-1:0] tix_in;
        if (k == 0) begin : g_head
            assign tok_in = '0;
            assign tix_in = '0;
        end else begin : g_link
            assign tok_in = tok[k-1];
            assign tix_in = tix[k-1];
        end
        eds_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_bc      (bc),
            .i_ref_idx (r_cursor),
            .i_wr_idx  (x_end[eds_pkg::IX_FREE]),
            .i_clr_idx (clr_idx),
            .i_tok     (tok_in),
            .i_tix     (tix_in),
            .o_tok     (tok[k]),
            .o_tix     (tix[k]),
            .o_valid   (v_vec[k])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            eds_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((i_cmd == eds_pkg::CMD_SERVE) && (r_count == '0)) begin
                        n_state = eds_pkg::S_DONE;
                    end else begin
                        n_state = eds_pkg::S_SCAN;
                    end
                end
            end
            eds_pkg::S_SCAN: begin
                if (scan_end && !((r_cmd == eds_pkg::CMD_SERVE) && r_mode &&
                                  !r_phase)) begin
                    n_state = eds_pkg::S_DONE;
                end
            end
            eds_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = eds_pkg::S_IDLE;
                end
            end
            default: n_state = eds_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        unique case (r_state)
            eds_pkg::S_IDLE: o_in_stall = 1'b0;
            default:         o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= eds_pkg::S_IDLE;
            r_mode      <= 1'b1;
            r_ins       <= '0;
            r_cursor    <= '0;
            r_at_end    <= 1'b1;
            r_up        <= 1'b1;
            r_last_cyl  <= '0;
            r_seek      <= '0;
            r_count     <= '0;
            r_cnt       <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_cnt   <= '0;
                r_phase <= cur_live;
            end else if ((r_state == eds_pkg::S_SCAN) && !scan_end) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (put_ok) begin
                r_ins   <= r_ins + eds_pkg::ORD_W'(1);
                r_count <= r_count + CW'(1);
            end
            // sweep turned at the top: start from the largest entry, going down
            if (scan_end && (r_cmd == eds_pkg::CMD_SERVE) && r_mode && !r_phase) begin
                r_cursor <= x_end[eds_pkg::IX_BIG];
                r_at_end <= 1'b0;
                r_up     <= 1'b0;
                r_phase  <= 1'b1;
                r_cnt    <= '0;
            end
            if (serve_fin) begin
                r_count    <= r_count - CW'(1);
                r_last_cyl <= t_end.sel_cyl;
                if (seek_hit && (r_seek != '1)) begin
                    r_seek <= r_seek + eds_pkg::SEEK_W'(1);
                end
                if (r_mode) begin
                    if (r_up ? t_end.succ_f : t_end.pred_f) begin
                        r_cursor <= r_up ? x_end[eds_pkg::IX_SUCC]
                                         : x_end[eds_pkg::IX_PRED];
                    end else if (!r_up && t_end.succ_f) begin
                        r_cursor <= x_end[eds_pkg::IX_SUCC];
                        r_up     <= 1'b1;
                    end else begin
                        r_cursor <= '0;
                        r_at_end <= 1'b1;
                        r_up     <= !r_up ? 1'b1 : r_up;
                    end
                end
            end
            if ((r_state == eds_pkg::S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd        <= i_cmd;
            r_key        <= {i_cylinder, i_arrival_time};
            r_pay        <= {i_head, i_sector, i_is_read, i_data_tag};
            r_res_status <= eds_pkg::ST_EMPTY;
            r_res_cyl    <= '0;
            r_res_pay    <= '0;
        end
        if (put_ok && (x_end[eds_pkg::IX_FREE] == r_cursor)) begin
            r_cur_key <= r_key;
        end
        if (scan_end && (r_cmd == eds_pkg::CMD_SERVE) && r_mode && !r_phase) begin
            r_cur_key <= t_end.big_key;
        end
        if (serve_fin && r_mode) begin
            if (r_up ? t_end.succ_f : t_end.pred_f) begin
                r_cur_key <= r_up ? t_end.succ_key : t_end.pred_key;
            end else if (!r_up && t_end.succ_f) begin
                r_cur_key <= t_end.succ_key;
            end
        end
        if (scan_end) begin
            if (r_cmd == eds_pkg::CMD_PUT) begin
                if (r_mode && t_end.dup) begin
                    r_res_status <= eds_pkg::ST_DUP;
                end else if (!t_end.free_f) begin
                    r_res_status <= eds_pkg::ST_FULL;
                end else begin
                    r_res_status <= eds_pkg::ST_ACCEPTED;
                end
            end else if (serve_fin) begin
                r_res_status <= eds_pkg::ST_SERVED;
                r_res_cyl    <= t_end.sel_cyl;
                r_res_pay    <= t_end.sel_pay;
            end
        end
        if ((r_state == eds_pkg::S_DONE) && out_free) begin
            r_o_status <= r_res_status;
            r_o_cyl    <= r_res_cyl;
            r_o_pay    <= r_res_pay;
            r_o_seek   <= r_seek;
            r_o_empty  <= (r_count == '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_out_cylinder = r_o_cyl;
    assign o_out_head     = r_o_pay[26:23];
    assign o_out_sector   = r_o_pay[22:17];
    assign o_out_is_read  = r_o_pay[16];
    assign o_out_data_tag = r_o_pay[15:0];
    assign o_seek_count   = r_o_seek;
    assign o_table_empty  = r_o_empty;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("pending count beyond table depth");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eds_pkg::S_IDLE) |-> ($countones(v_vec) == 32'(r_count)))
        else $error("pending count differs from valid slots");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eds_pkg::S_SCAN) |-> (r_cnt <= DEPTH_C))
        else $error("scan counter overran the chain");

    a_one_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eds_pkg::S_IDLE) |=>
            ($countones(v_vec ^ $past(v_vec)) == 0))
        else $error("table changed with no command in flight");

endmodule

`default_nettype wire
